[design/mnva_pkg.sv]
// ----------------------------------------------------------------------------
// mnva_pkg
// Shared types, codes and the key-to-frequency function of the MIDI note
// voice allocator.
// ----------------------------------------------------------------------------
package mnva_pkg;

  // Command codes on the result port.
  localparam logic [1:0] CMD_ON    = 2'd0;
  localparam logic [1:0] CMD_OFF   = 2'd1;
  localparam logic [1:0] CMD_PRESS = 2'd2;

  // A free voice holds this marker.
  localparam logic [15:0] FREE_VOICE = 16'hFFFF;

  // Keys below LOW_KEY sound at LOW_FREQ.
  localparam logic [6:0]  LOW_KEY          = 7'd36;
  localparam logic [15:0] LOW_FREQ         = 16'd60;
  localparam int          NOTES_PER_OCTAVE = 12;
  localparam int          NUM_OCTAVES      = 8;

  // Width of the channel field in a status byte.
  localparam int CHAN_W = 4;

  // Depth of the request queue between parser and executor.
  localparam int QDEPTH = 2;

  // One request from the parser to the executor.
  typedef struct packed {
    logic [1:0]        cmd;
    logic [CHAN_W-1:0] chan;
    logic [15:0]       freq;
    logic [6:0]        pressure;
  } req_t;

  // Base frequencies of the lowest octave, C2 to B2, in whole hertz.
  function automatic logic [15:0] base_freq(input logic [3:0] note);
    logic [15:0] f;
    begin
      case (note)
        4'd0:    f = 16'd65;
        4'd1:    f = 16'd69;
        4'd2:    f = 16'd73;
        4'd3:    f = 16'd78;
        4'd4:    f = 16'd82;
        4'd5:    f = 16'd87;
        4'd6:    f = 16'd93;
        4'd7:    f = 16'd98;
        4'd8:    f = 16'd104;
        4'd9:    f = 16'd110;
        4'd10:   f = 16'd117;
        4'd11:   f = 16'd123;
        default: f = 16'd0;
      endcase
      base_freq = f;
    end
  endfunction

  // Key to frequency: the octave is found by comparing against constant
  // thresholds, the note within the octave by subtracting the octave's offset.
  function automatic logic [15:0] key_to_freq(input logic [6:0] key);
    logic [6:0] k;
    logic [2:0] oct;
    logic [6:0] note;
    begin
      k   = key - LOW_KEY;
      oct = 3'd0;
      for (int i = 1; i < NUM_OCTAVES; i++) begin
        if (k >= 7'(i * NOTES_PER_OCTAVE)) begin
          oct = 3'(i);
        end
      end
      note = k - 7'(32'(oct) * NOTES_PER_OCTAVE);
      if (key < LOW_KEY) begin
        key_to_freq = LOW_FREQ;
      end else begin
        key_to_freq = base_freq(note[3:0]) << oct;
      end
    end
  endfunction

endpackage

[design/mnva_ram.sv]
// ----------------------------------------------------------------------------
// mnva_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mnva_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/mnva_parser.sv]
// ----------------------------------------------------------------------------
// mnva_parser
// Front end: takes MIDI bytes, tracks the message being received and hands
// each complete note-on, note-off or poly pressure message on as a request.
// ----------------------------------------------------------------------------
module mnva_parser #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        midi_byte,
  input  logic              q_full,
  output logic              full,
  output logic              q_push,
  output mnva_pkg::req_t    q_data
);

  // Message types being received.
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_NOTE_OFF = 3'd1;
  localparam logic [2:0] MODE_NOTE_ON  = 3'd2;
  localparam logic [2:0] MODE_POLY     = 3'd3;
  localparam logic [2:0] MODE_CC       = 3'd4;
  localparam logic [2:0] MODE_PROG     = 3'd5;
  localparam logic [2:0] MODE_CHPRESS  = 3'd6;
  localparam logic [2:0] MODE_BEND     = 3'd7;

  localparam logic [mnva_pkg::CHAN_W-1:0] LAST_CHAN =
    mnva_pkg::CHAN_W'(NUM_CHANNELS - 1);

  logic [2:0]                  parse_mode;
  logic [1:0]                  byte_step;
  logic [mnva_pkg::CHAN_W-1:0] held_channel;
  logic [6:0]                  held_key;

  logic                        accept;
  logic [6:0]                  data7;
  logic [2:0]                  mode_next;
  logic [mnva_pkg::CHAN_W-1:0] chan_fold;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign data7  = midi_byte[6:0];

  // Decode the message type from a status byte.
  always_comb begin
    case (midi_byte[7:4])
      4'h8:    mode_next = MODE_NOTE_OFF;
      4'h9:    mode_next = MODE_NOTE_ON;
      4'hA:    mode_next = MODE_POLY;
      4'hB:    mode_next = MODE_CC;
      4'hC:    mode_next = MODE_PROG;
      4'hD:    mode_next = MODE_CHPRESS;
      4'hE:    mode_next = MODE_BEND;
      default: mode_next = MODE_IDLE;
    endcase
    chan_fold = (midi_byte[3:0] > LAST_CHAN) ? LAST_CHAN : midi_byte[3:0];
  end

  // A request leaves on the second data byte of a note or pressure message.
  always_comb begin
    q_push = accept && (parse_mode != MODE_IDLE) && (byte_step == 2'd2) &&
             (parse_mode == MODE_NOTE_OFF || parse_mode == MODE_NOTE_ON ||
              parse_mode == MODE_POLY);
    case (parse_mode)
      MODE_NOTE_ON:  q_data.cmd = mnva_pkg::CMD_ON;
      MODE_NOTE_OFF: q_data.cmd = mnva_pkg::CMD_OFF;
      default:       q_data.cmd = mnva_pkg::CMD_PRESS;
    endcase
    q_data.chan     = held_channel;
    q_data.freq     = mnva_pkg::key_to_freq(held_key);
    q_data.pressure = data7;
  end

  // Message tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode   <= MODE_IDLE;
      byte_step    <= 2'd0;
      held_channel <= '0;
      held_key     <= '0;
    end else if (accept) begin
      if (parse_mode == MODE_IDLE) begin
        if (midi_byte[7]) begin
          parse_mode   <= mode_next;
          held_channel <= chan_fold;
          byte_step    <= (mode_next == MODE_IDLE) ? 2'd0 : 2'd1;
        end
      end else if (byte_step <= 2'd1) begin
        held_key <= data7;
        if (parse_mode == MODE_PROG || parse_mode == MODE_CHPRESS) begin
          parse_mode <= MODE_IDLE;
          byte_step  <= 2'd0;
        end else begin
          byte_step <= 2'd2;
        end
      end else begin
        parse_mode <= MODE_IDLE;
        byte_step  <= 2'd0;
      end
    end
  end

endmodule

[design/mnva_fifo.sv]
// ----------------------------------------------------------------------------
// mnva_fifo
// Short request queue between the parser and the voice executor.
// ----------------------------------------------------------------------------
module mnva_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  mnva_pkg::req_t wr_data,
  input  logic           rd_en,
  output mnva_pkg::req_t rd_data,
  output logic           q_full,
  output logic           q_empty
);

  localparam int PW = (mnva_pkg::QDEPTH > 1) ? $clog2(mnva_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(mnva_pkg::QDEPTH + 1);

  mnva_pkg::req_t slots [mnva_pkg::QDEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;

  logic do_wr;
  logic do_rd;

  assign q_full  = (32'(count) == mnva_pkg::QDEPTH);
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (32'(wptr) == mnva_pkg::QDEPTH - 1) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (32'(rptr) == mnva_pkg::QDEPTH - 1) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[design/mnva_exec.sv]
// ----------------------------------------------------------------------------
// mnva_exec
// Back end: holds the voice counts and the voice table, searches a channel's
// voices one per cycle for each request and produces the result.
// ----------------------------------------------------------------------------
module mnva_exec #(
  parameter int NUM_CHANNELS = 8,
  parameter int MAX_VOICES   = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [3:0]     cfg_data,
  input  logic           q_empty,
  input  mnva_pkg::req_t q_data,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic [1:0]     command,
  output logic [2:0]     chan_index,
  output logic [2:0]     voice_index,
  output logic [15:0]    tone_freq,
  output logic [6:0]     pressure
);

  localparam int DEPTH = NUM_CHANNELS * MAX_VOICES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(MAX_VOICES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;

  logic [3:0]     voice_count [NUM_CHANNELS];
  logic [1:0]     state;
  mnva_pkg::req_t job;
  logic [NW-1:0]  v;
  logic [DEPTH-1:0] written;
  logic           rd_free_q;
  logic [AW-1:0]  rd_addr_q;
  logic           out_valid;

  logic [3:0]     cnt_raw;
  logic [NW-1:0]  n_act;
  logic [NW-1:0]  v_rd;
  logic [NW-1:0]  v_inc;
  logic [AW-1:0]  rd_addr;
  logic           rd_en;
  logic [15:0]    ram_q;
  logic [15:0]    cur;
  logic [15:0]    target;
  logic           hit;
  logic           wr_en;
  logic [15:0]    wr_data;

  // Voice count registers, one per channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        voice_count[c] <= 4'd1;
      end
    end else if (cfg_we) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (32'(cfg_index) == c) begin
          voice_count[c] <= cfg_data;
        end
      end
    end
  end

  // Active voices of the request's channel, clamped to the table size.
  always_comb begin
    cnt_raw = 4'd0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (32'(job.chan) == c) begin
        cnt_raw = voice_count[c];
      end
    end
    n_act = (32'(cnt_raw) > MAX_VOICES) ? NW'(MAX_VOICES) : NW'(cnt_raw);
  end

  // Search compare on the voice read last cycle.
  always_comb begin
    cur     = rd_free_q ? mnva_pkg::FREE_VOICE : ram_q;
    target  = (job.cmd == mnva_pkg::CMD_ON) ? mnva_pkg::FREE_VOICE : job.freq;
    hit     = (state == ST_CHECK) && (cur == target);
    v_inc   = v + NW'(1);
    v_rd    = (state == ST_CHECK) ? v_inc : '0;
    rd_addr = AW'(32'(job.chan) * MAX_VOICES + 32'(v_rd));
    rd_en   = ((state == ST_ISSUE) && (n_act != '0)) ||
              ((state == ST_CHECK) && !hit && (v_inc < n_act));
    wr_en   = hit && (job.cmd != mnva_pkg::CMD_PRESS);
    wr_data = (job.cmd == mnva_pkg::CMD_ON) ? job.freq : mnva_pkg::FREE_VOICE;
    q_pop   = (state == ST_IDLE) && !q_empty && !out_valid;
  end

  mnva_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_voice_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (rd_addr_q),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // An entry that was never written reads as a free voice.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[rd_addr_q] <= 1'b1;
    end
  end

  // Read-side tags that travel with the registered RAM data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_free_q <= !written[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      v     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          v     <= '0;
          state <= (n_act != '0) ? ST_CHECK : ST_IDLE;
        end
        ST_CHECK: begin
          if (rd_en) begin
            v <= v_inc;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Request held while it is worked on.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      command     <= job.cmd;
      chan_index  <= 3'(job.chan);
      voice_index <= 3'(v);
      tone_freq   <= (job.cmd == mnva_pkg::CMD_ON) ? job.freq : 16'd0;
      pressure    <= (job.cmd == mnva_pkg::CMD_PRESS) ? job.pressure : 7'd0;
    end
  end

  assign empty = !out_valid;

endmodule

[design/midi_note_voice_allocator.sv]
// ----------------------------------------------------------------------------
// midi_note_voice_allocator
// MIDI byte parser with per-channel polyphonic voice allocation.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the request queue has room.
// The executor works on one request at a time, searching one voice per cycle,
// and waits while a result is not yet popped.
// Reset clears parser state, the queue and the voice valid bits at once;
// voice counts return to 1. There is no clearing pass.
module midi_note_voice_allocator #(
  parameter int NUM_CHANNELS = 8,
  parameter int MAX_VOICES   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  midi_byte,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  command,
  output logic [2:0]  chan_index,
  output logic [2:0]  voice_index,
  output logic [15:0] tone_freq,
  output logic [6:0]  pressure
);

  logic           q_push;
  mnva_pkg::req_t q_wdata;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  mnva_pkg::req_t q_rdata;

  // Front end: message parser.
  mnva_parser #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .midi_byte (midi_byte),
    .q_full    (q_full),
    .full      (full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // Request queue.
  mnva_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Back end: voice search and result.
  mnva_exec #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_VOICES   (MAX_VOICES)
  ) u_exec (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .command     (command),
    .chan_index  (chan_index),
    .voice_index (voice_index),
    .tone_freq   (tone_freq),
    .pressure    (pressure)
  );

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Regression for the MIDI note voice allocator. A short table of MIDI bytes
// covers the reset voice counts, key extremes, channel folding, dropped notes,
// unmatched note-offs and consumed messages. Random phases with different
// voice counts and idling patterns follow. Every accepted byte goes through
// a local model of the parser and voice tables, and each popped result is
// compared with the oldest predicted command.
// ----------------------------------------------------------------------------
module tb;
  import mnva_pkg::*;

  localparam int NUM_CH      = 8;
  localparam int MAX_VC      = 8;
  localparam int DIR_LEN     = 32;
  localparam int PHASE_ITEMS = 200;
  localparam int SETTLE      = 5 * MAX_VC + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_MAX   = 20000;
  localparam int LIMIT       = 2000000;

  // Base frequencies C2..B2, note 0 in the low 16 bits.
  localparam logic [12*16-1:0] NOTE_BASE = {
    16'd123, 16'd117, 16'd110, 16'd104, 16'd98, 16'd93,
    16'd87,  16'd82,  16'd78,  16'd73,  16'd69, 16'd65
  };

  // Voice counts with the extremes, channel 0 in the low nibble.
  localparam logic [31:0] EDGE_CNT = {4'd3, 4'd15, 4'd0, 4'd9, 4'd1, 4'd8, 4'd15, 4'd0};

  typedef enum logic [2:0] {
    PM_IDLE, PM_NOTE_OFF, PM_NOTE_ON, PM_POLY, PM_CC, PM_PROG, PM_CHPRESS, PM_BEND
  } parse_mode_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  chan;
    logic [2:0]  voice;
    logic [15:0] freq;
    logic [6:0]  press;
  } voice_cmd_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fixed;
    voice_cmd_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  midi_byte = 8'h00;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [3:0]  cfg_data = 4'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  command;
  logic [2:0]  chan_index;
  logic [2:0]  voice_index;
  logic [15:0] tone_freq;
  logic [6:0]  pressure;

  // Model state.
  logic [15:0] voice_freq [NUM_CH][MAX_VC];
  logic [3:0]  voice_cnt [NUM_CH];
  parse_mode_t pmode;
  logic [1:0]  pstep;
  logic [2:0]  pchan;
  logic [6:0]  pkey;

  voice_cmd_t  expected_cmds [$];
  voice_cmd_t  want;
  voice_cmd_t  got;
  logic [3:0]  next_cnt [NUM_CH];
  logic [6:0]  key_pool [8];
  int          errors = 0;
  int          leftover = 0;
  int          sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_asked = 0;
  int          hold_done = 0;
  int          hold_left = 0;

  // Directed bytes; typed results only where they are obvious.
  stim_row_t dir_rows [DIR_LEN] = '{
    {8'h45, 1'b0, 31'd0},
    {8'h90, 1'b0, 31'd0}, {8'h00, 1'b0, 31'd0},
    {8'h7F, 1'b1, CMD_ON, 3'd0, 3'd0, 16'd60, 7'd0},
    {8'h90, 1'b0, 31'd0}, {8'h7F, 1'b0, 31'd0}, {8'h00, 1'b0, 31'd0},
    {8'h80, 1'b0, 31'd0}, {8'h00, 1'b0, 31'd0},
    {8'h40, 1'b1, CMD_OFF, 3'd0, 3'd0, 16'd0, 7'd0},
    {8'h80, 1'b0, 31'd0}, {8'h00, 1'b0, 31'd0}, {8'h00, 1'b0, 31'd0},
    {8'h9F, 1'b0, 31'd0}, {8'h7F, 1'b0, 31'd0},
    {8'h00, 1'b1, CMD_ON, 3'd7, 3'd0, 16'd12544, 7'd0},
    {8'hAF, 1'b0, 31'd0}, {8'h7F, 1'b0, 31'd0},
    {8'h7F, 1'b1, CMD_PRESS, 3'd7, 3'd0, 16'd0, 7'd127},
    {8'hB3, 1'b0, 31'd0}, {8'h01, 1'b0, 31'd0}, {8'h02, 1'b0, 31'd0},
    {8'hC3, 1'b0, 31'd0}, {8'h05, 1'b0, 31'd0},
    {8'hFF, 1'b0, 31'd0}, {8'h12, 1'b0, 31'd0},
    {8'h91, 1'b0, 31'd0}, {8'hC0, 1'b0, 31'd0},
    {8'h90, 1'b1, CMD_ON, 3'd1, 3'd0, 16'd328, 7'd0},
    {8'h8F, 1'b0, 31'd0}, {8'h7F, 1'b0, 31'd0},
    {8'h00, 1'b1, CMD_OFF, 3'd7, 3'd0, 16'd0, 7'd0}
  };

  midi_note_voice_allocator #(
    .NUM_CHANNELS(NUM_CH),
    .MAX_VOICES  (MAX_VC)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .midi_byte  (midi_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .empty      (empty),
    .pop        (pop),
    .command    (command),
    .chan_index (chan_index),
    .voice_index(voice_index),
    .tone_freq  (tone_freq),
    .pressure   (pressure)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Frequency of a key: low keys sit at the floor, others shift by octave.
  function automatic logic [15:0] note_freq(input logic [6:0] key);
    int k;
    if (key < LOW_KEY) return LOW_FREQ;
    k = int'(key) - int'(LOW_KEY);
    return NOTE_BASE[(k % NOTES_PER_OCTAVE) * 16 +: 16] << (k / NOTES_PER_OCTAVE);
  endfunction

  // Advance the parser and voice tables by one byte; returns 1 with a command.
  function automatic bit predict_byte(input logic [7:0] b, output voice_cmd_t r);
    logic [6:0]  d;
    logic [15:0] f;
    logic [15:0] tgt;
    parse_mode_t m;
    int          n;
    int          v;
    bit          hit;
    d   = b[6:0];
    hit = 1'b0;
    r   = '0;
    if (pmode == PM_IDLE) begin
      // Data bytes while idle are dropped; a status byte opens a message.
      if (b[7]) begin
        case (b[7:4])
          4'h8:    m = PM_NOTE_OFF;
          4'h9:    m = PM_NOTE_ON;
          4'hA:    m = PM_POLY;
          4'hB:    m = PM_CC;
          4'hC:    m = PM_PROG;
          4'hD:    m = PM_CHPRESS;
          4'hE:    m = PM_BEND;
          default: m = PM_IDLE;
        endcase
        pmode = m;
        pchan = (b[3:0] >= NUM_CH) ? 3'(NUM_CH - 1) : b[2:0];
        pstep = (m == PM_IDLE) ? 2'd0 : 2'd1;
      end
    end else if (pstep <= 2'd1) begin
      pkey = d;
      if (pmode == PM_PROG || pmode == PM_CHPRESS) begin
        pmode = PM_IDLE;
        pstep = 2'd0;
      end else begin
        pstep = 2'd2;
      end
    end else begin
      // Last byte of a three-byte message: search the active voices.
      m     = pmode;
      pmode = PM_IDLE;
      pstep = 2'd0;
      f     = note_freq(pkey);
      tgt   = (m == PM_NOTE_ON) ? FREE_VOICE : f;
      n     = (voice_cnt[pchan] > MAX_VC) ? MAX_VC : int'(voice_cnt[pchan]);
      v     = -1;
      for (int i = 0; i < n; i++) begin
        if (v < 0 && voice_freq[pchan][i] == tgt) v = i;
      end
      if (v >= 0) begin
        case (m)
          PM_NOTE_ON: begin
            voice_freq[pchan][v] = f;
            r   = {CMD_ON, pchan, 3'(v), f, 7'd0};
            hit = 1'b1;
          end
          PM_NOTE_OFF: begin
            voice_freq[pchan][v] = FREE_VOICE;
            r   = {CMD_OFF, pchan, 3'(v), 16'd0, 7'd0};
            hit = 1'b1;
          end
          PM_POLY: begin
            r   = {CMD_PRESS, pchan, 3'(v), 16'd0, d};
            hit = 1'b1;
          end
          default: ;
        endcase
      end
    end
    return hit;
  endfunction

  // Offer one byte after a random gap and predict once it is taken.
  task automatic send_byte(input logic [7:0] b, input logic fixed, input voice_cmd_t typed);
    int         gap;
    voice_cmd_t r;
    bit         hit;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    midi_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
    hit = predict_byte(b, r);
    if (fixed) expected_cmds.push_back(typed);
    else if (hit) expected_cmds.push_back(r);
  endtask

  // Data byte; now and then a status byte lands inside the message.
  function automatic logic [7:0] data_byte(input logic [6:0] val);
    return {($urandom_range(99) < 4), val};
  endfunction

  function automatic logic [6:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(7)];
    return 7'($urandom_range(127));
  endfunction

  // One random message: mostly well-formed channel messages, some noise.
  task automatic send_message();
    int unsigned sel;
    int unsigned n;
    logic [3:0]  chan;
    logic [3:0]  kind;
    sel  = $urandom_range(99);
    chan = 4'($urandom_range(15));
    if (sel < 80) begin
      if (sel < 35) kind = 4'h9;
      else if (sel < 60) kind = 4'h8;
      else if (sel < 72) kind = 4'hA;
      else kind = 4'(4'hB + $urandom_range(3));
      send_byte({kind, chan}, 1'b0, '0);
      send_byte(data_byte(pick_key()), 1'b0, '0);
      if (kind != 4'hC && kind != 4'hD) begin
        send_byte(data_byte(7'($urandom_range(127))), 1'b0, '0);
      end
    end else if (sel < 86) begin
      // System message; its trailing data bytes arrive while idle.
      send_byte({4'hF, chan}, 1'b0, '0);
      n = $urandom_range(2);
      repeat (n) send_byte({1'b0, 7'($urandom_range(127))}, 1'b0, '0);
    end else if (sel < 93) begin
      // Note or pressure message with a status byte where its first data byte goes.
      send_byte({4'(4'h8 + $urandom_range(2)), chan}, 1'b0, '0);
      send_byte({1'b1, 7'($urandom_range(127))}, 1'b0, '0);
      send_byte(8'($urandom_range(255)), 1'b0, '0);
    end else begin
      send_byte(8'($urandom_range(255)), 1'b0, '0);
    end
  endtask

  // Stop offering, wait for every predicted command, then let the block settle.
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all voice counts back to back.
  task automatic write_counts();
    for (int c = 0; c < NUM_CH; c++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(c);
      cfg_data  <= next_cnt[c];
      @(posedge clk);
      voice_cnt[c] = next_cnt[c];
    end
    cfg_we <= 1'b0;
  endtask

  // Result side: check each popped command, then decide the next pop.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = {command, chan_index, voice_index, tone_freq, pressure};
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected command %0d ch %0d voice %0d freq %0d press %0d",
                   $time, got.cmd, got.chan, got.voice, got.freq, got.press);
          errors++;
        end else begin
          want = expected_cmds.pop_front();
          if (got !== want) begin
            $display("%0t: expected cmd %0d ch %0d voice %0d freq %0d press %0d",
                     $time, want.cmd, want.chan, want.voice, want.freq, want.press);
            $display("%0t:   actual cmd %0d ch %0d voice %0d freq %0d press %0d",
                     $time, got.cmd, got.chan, got.voice, got.freq, got.press);
            errors++;
          end
        end
      end
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin
    int target;
    int drain;
    for (int c = 0; c < NUM_CH; c++) begin
      voice_cnt[c] = 4'd1;
      for (int v = 0; v < MAX_VC; v++) voice_freq[c][v] = FREE_VOICE;
    end
    pmode = PM_IDLE;
    pstep = 2'd0;
    pchan = 3'd0;
    pkey  = 7'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part runs with the voice counts left by reset.
    for (int i = 0; i < DIR_LEN; i++) begin
      send_byte(dir_rows[i].b, dir_rows[i].fixed, dir_rows[i].res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      for (int c = 0; c < NUM_CH; c++) begin
        case (ph)
          0:       next_cnt[c] = 4'(MAX_VC);
          2:       next_cnt[c] = EDGE_CNT[c * 4 +: 4];
          default: next_cnt[c] = 4'($urandom_range(15));
        endcase
      end
      write_counts();
      for (int k = 0; k < 8; k++) key_pool[k] = 7'($urandom_range(127));
      case (ph)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // Last phase: the result side stalls long enough to back up the input.
      if (ph == 3) hold_asked++;
      target = sent + PHASE_ITEMS;
      while (sent < target) send_message();
    end

    // Drain, with a bound, then allow the block's latency to pass.
    push <= 1'b0;
    drain = 0;
    while (expected_cmds.size() != 0 && drain < DRAIN_MAX) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE) @(posedge clk);
    if (expected_cmds.size() != 0) begin
      leftover = expected_cmds.size();
      $display("%0t: %0d expected commands never arrived", $time, leftover);
    end
    if (errors == 0 && leftover == 0) begin
      $display("midi_note_voice_allocator regression: pass");
    end else begin
      $display("midi_note_voice_allocator regression: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(LIMIT);
    $display("midi_note_voice_allocator regression: fail");
    $finish;
  end

endmodule
